FILE: rtl/ssg_pkg.sv
// Shared types and constants for the step sequencer with glide.
// Holds table sizes, fixed-point widths, register map, item kinds and sequencer states.
// No dependencies.
package ssg_pkg;

    // Step table
    localparam int MAX_STEPS = 16;
    localparam int IDX_W     = $clog2(MAX_STEPS);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    // Lengths, levels and fixed point
    localparam int LEN_W   = 16;
    localparam int LVL_W   = 8;
    localparam int FRAC_W  = 22;
    localparam int ACC_W   = 32;
    localparam int INT_W   = ACC_W - FRAC_W;
    localparam int DIFF_W  = ACC_W + 2;

    // Serial divider runs one quotient bit per cycle
    localparam int DIV_STEPS = ACC_W;
    localparam int ITER_W    = $clog2(DIV_STEPS);

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_STEP_LENGTH   = 3'd0;
    localparam logic [2:0] REG_GLIDE_LENGTH  = 3'd1;
    localparam logic [2:0] REG_UNIFORM_MODE  = 3'd2;
    localparam logic [2:0] REG_DEFAULT_LEVEL = 3'd3;
    localparam logic [2:0] REG_LEVEL_MIN     = 3'd4;
    localparam logic [2:0] REG_LEVEL_MAX     = 3'd5;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_STEP_LENGTH   = 16'd1000;
    localparam logic [LEN_W-1:0] RST_GLIDE_LENGTH  = 16'd1;
    localparam logic             RST_UNIFORM_MODE  = 1'b1;
    localparam logic [LVL_W-1:0] RST_DEFAULT_LEVEL = 8'd0;
    localparam logic [LVL_W-1:0] RST_LEVEL_MIN     = 8'd0;
    localparam logic [LVL_W-1:0] RST_LEVEL_MAX     = 8'd255;

    // Input word kinds
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SET    = 2'd2
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ABS,
        ST_DIV,
        ST_SIGN,
        ST_ACCUM,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/step_sequencer_with_glide.sv
// Step sequencer with glide: step table, phase counter, serial slope divider.
// Depends on ssg_pkg.
//
// Usage:
//   s_axis carries one word per tick or table write. tuser holds the kind
//   (0 tick, 1 append step, 2 overwrite step, 3 ignored). Only ticks return
//   a word on m_axis: tdata is the level, clamped on glide updates; tlast
//   is set when that tick wrapped the sequence back to step zero.
//   The APB port reads and writes the six setup registers at 4*i; write
//   them only while the block is idle.
// Flow:
//   Appends, ignored kinds and overwrites of another step leave the block
//   idle. A tick on an empty table or with gate low goes straight to the
//   output state, a tick inside a step through accumulate first. A tick
//   that moves to a new step runs read, setup, a restoring divider that
//   makes one quotient bit at a time, sign, accumulate and output. An
//   overwrite of the current step runs setup, the divider and sign.
//   s_axis_tready is low while an item works.
// Reset clears the table count, phase, accumulator and output valid flag.
// A stalled receiver holds the result in the output register; the next
// item is still accepted, and its own result waits until the register frees.
module step_sequencer_with_glide
    import ssg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] gate, [4:1] entry_index, [12:5] entry_value, [28:13] entry_length,
    // [29] use_config_length, [31:30] zero
    input  logic [31:0]       s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]        s_axis_tuser,

    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [7:0] level
    output logic [LVL_W-1:0]  m_axis_tdata,
    // end_of_sequence
    output logic              m_axis_tlast,

    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic [LEN_W-1:0] step_len_reg, step_len_next;
    logic [LEN_W-1:0] glide_len_reg, glide_len_next;
    logic             uniform_reg, uniform_next;
    logic [LVL_W-1:0] def_level_reg, def_level_next;
    logic [LVL_W-1:0] lvl_min_reg, lvl_min_next;
    logic [LVL_W-1:0] lvl_max_reg, lvl_max_next;

    // Sequencer state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0] phase_reg, phase_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] slope_reg, slope_next;
    logic [LVL_W-1:0] held_reg, held_next;
    logic             tick_reg, tick_next;
    logic             eos_reg, eos_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    logic [DIFF_W-1:0] diff_reg, diff_next;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  quot_reg, quot_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [LVL_W-1:0]  res_level_reg, res_level_next;
    logic [LVL_W-1:0]  out_level_reg, out_level_next;
    logic              out_last_reg, out_last_next;

    // Step table
    logic [LVL_W-1:0] lvl_mem [MAX_STEPS];
    logic [LEN_W-1:0] len_mem [MAX_STEPS];
    logic [LVL_W-1:0] rd_lvl_reg;
    logic [LEN_W-1:0] rd_len_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;

    // Input fields
    logic             in_fire;
    logic             in_gate;
    logic [IDX_W-1:0] in_index;
    logic [LVL_W-1:0] in_value;
    logic [LEN_W-1:0] in_length;
    logic             in_use_cfg;

    // Helper values
    logic             cfg_we;
    logic [LEN_W-1:0] eff_glide;
    logic [LEN_W-1:0] wlen;
    logic [LEN_W:0]   rem_diff;
    logic [LEN_W-1:0] set_remain;
    logic [CNT_W-1:0] nxt_step;
    logic             wrap;
    logic [LEN_W:0]   trial;
    logic             trial_ge;
    logic [LEN_W:0]   trial_sub;
    logic [DIFF_W-1:0] diff_mag;
    logic [ACC_W-1:0] acc_sum;
    logic signed [INT_W-1:0] int_part;
    logic signed [INT_W-1:0] int_lo;
    logic signed [INT_W-1:0] int_clamp;

    // Unpack input word
    assign in_gate    = s_axis_tdata[0];
    assign in_index   = s_axis_tdata[4:1];
    assign in_value   = s_axis_tdata[12:5];
    assign in_length  = s_axis_tdata[28:13];
    assign in_use_cfg = s_axis_tdata[29];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_level_reg;
    assign m_axis_tlast  = out_last_reg;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // Shared derived values
    assign eff_glide  = (glide_len_reg == '0) ? LEN_W'(1) : glide_len_reg;
    assign wlen       = in_use_cfg ? step_len_reg : in_length;
    assign rem_diff   = {1'b0, wlen} - {1'b0, phase_reg};
    assign set_remain = (rem_diff[LEN_W] || (rem_diff <= (LEN_W+1)'(1)))
                        ? LEN_W'(1) : rem_diff[LEN_W-1:0];
    assign nxt_step   = CNT_W'(cur_reg) + CNT_W'(1);
    assign wrap       = (nxt_step >= count_reg);
    assign mem_raddr  = wrap ? '0 : nxt_step[IDX_W-1:0];

    // Divider step: shift one dividend bit in, subtract if it fits
    assign trial     = {rem_reg, quot_reg[ACC_W-1]};
    assign trial_sub = trial - {1'b0, eff_glide};
    assign trial_ge  = !trial_sub[LEN_W] || (trial >= {1'b0, eff_glide});
    assign diff_mag  = diff_reg[DIFF_W-1] ? (~diff_reg + DIFF_W'(1)) : diff_reg;

    // Accumulate and clamp the integer part
    assign acc_sum   = acc_reg + slope_reg;
    assign int_part  = $signed(acc_sum[ACC_W-1:FRAC_W]);
    assign int_lo    = (int_part < $signed({2'b00, lvl_min_reg}))
                       ? $signed({2'b00, lvl_min_reg}) : int_part;
    assign int_clamp = (int_lo > $signed({2'b00, lvl_max_reg}))
                       ? $signed({2'b00, lvl_max_reg}) : int_lo;

    // Read back configuration
    always_comb
    begin
        unique case (paddr[4:2])
            REG_STEP_LENGTH:   prdata = DATA_W'(step_len_reg);
            REG_GLIDE_LENGTH:  prdata = DATA_W'(glide_len_reg);
            REG_UNIFORM_MODE:  prdata = DATA_W'(uniform_reg);
            REG_DEFAULT_LEVEL: prdata = DATA_W'(def_level_reg);
            REG_LEVEL_MIN:     prdata = DATA_W'(lvl_min_reg);
            REG_LEVEL_MAX:     prdata = DATA_W'(lvl_max_reg);
            default:           prdata = '0;
        endcase
    end

    // Next state and datapath control
    always_comb
    begin
        step_len_next  = step_len_reg;
        glide_len_next = glide_len_reg;
        uniform_next   = uniform_reg;
        def_level_next = def_level_reg;
        lvl_min_next   = lvl_min_reg;
        lvl_max_next   = lvl_max_reg;

        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        acc_next       = acc_reg;
        slope_next     = slope_reg;
        held_next      = held_reg;
        tick_next      = tick_reg;
        eos_next       = eos_reg;
        out_valid_next = out_valid_reg;

        diff_next      = diff_reg;
        neg_next       = neg_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        res_level_next = res_level_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;

        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];

        // Write configuration
        if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_STEP_LENGTH:   step_len_next  = pwdata[LEN_W-1:0];
                REG_GLIDE_LENGTH:  glide_len_next = pwdata[LEN_W-1:0];
                REG_UNIFORM_MODE:  uniform_next   = pwdata[0];
                REG_DEFAULT_LEVEL: def_level_next = pwdata[LVL_W-1:0];
                REG_LEVEL_MIN:     lvl_min_next   = pwdata[LVL_W-1:0];
                REG_LEVEL_MAX:     lvl_max_next   = pwdata[LVL_W-1:0];
                default:           ;
            endcase
        end

        // Drop the output word once taken
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        MODE_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_STEPS))
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_SET:
                        begin
                            if (CNT_W'(in_index) < count_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = in_index;
                                // Overwrite of the live step glides from here
                                if (in_index == cur_reg)
                                begin
                                    remain_next = set_remain;
                                    diff_next   = DIFF_W'({in_value, FRAC_W'(0)})
                                                  - {{2{acc_reg[ACC_W-1]}}, acc_reg};
                                    tick_next   = 1'b0;
                                    state_next  = ST_ABS;
                                end
                            end
                        end
                        MODE_TICK:
                        begin
                            eos_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                res_level_next = def_level_reg;
                                state_next     = ST_OUT;
                            end
                            else if (!in_gate)
                            begin
                                res_level_next = held_reg;
                                state_next     = ST_OUT;
                            end
                            else if (phase_reg >= remain_reg)
                            begin
                                // Advance to the next step
                                cur_next   = mem_raddr;
                                eos_next   = wrap;
                                phase_next = '0;
                                tick_next  = 1'b1;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_ACCUM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                remain_next = uniform_reg ? step_len_reg : rd_len_reg;
                diff_next   = DIFF_W'({rd_lvl_reg, FRAC_W'(0)})
                              - {{2{acc_reg[ACC_W-1]}}, acc_reg};
                state_next  = ST_ABS;
            end
            ST_ABS:
            begin
                neg_next   = diff_reg[DIFF_W-1];
                quot_next  = diff_mag[ACC_W-1:0];
                rem_next   = '0;
                iter_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
                quot_next = {quot_reg[ACC_W-2:0], trial_ge};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                slope_next = neg_reg ? (~quot_reg + ACC_W'(1)) : quot_reg;
                state_next = tick_reg ? ST_ACCUM : ST_IDLE;
            end
            ST_ACCUM:
            begin
                res_level_next = held_reg;
                if (phase_reg < eff_glide)
                begin
                    acc_next       = acc_sum;
                    held_next      = int_clamp[LVL_W-1:0];
                    res_level_next = int_clamp[LVL_W-1:0];
                end
                phase_next = phase_reg + LEN_W'(1);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register frees
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = res_level_reg;
                    out_last_next  = eos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len_reg  <= RST_STEP_LENGTH;
            glide_len_reg <= RST_GLIDE_LENGTH;
            uniform_reg   <= RST_UNIFORM_MODE;
            def_level_reg <= RST_DEFAULT_LEVEL;
            lvl_min_reg   <= RST_LEVEL_MIN;
            lvl_max_reg   <= RST_LEVEL_MAX;
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            phase_reg     <= '0;
            remain_reg    <= RST_STEP_LENGTH;
            acc_reg       <= ACC_W'({RST_DEFAULT_LEVEL, FRAC_W'(0)});
            slope_reg     <= '0;
            held_reg      <= RST_DEFAULT_LEVEL;
            tick_reg      <= 1'b0;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_len_reg  <= step_len_next;
            glide_len_reg <= glide_len_next;
            uniform_reg   <= uniform_next;
            def_level_reg <= def_level_next;
            lvl_min_reg   <= lvl_min_next;
            lvl_max_reg   <= lvl_max_next;
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            phase_reg     <= phase_next;
            remain_reg    <= remain_next;
            acc_reg       <= acc_next;
            slope_reg     <= slope_next;
            held_reg      <= held_next;
            tick_reg      <= tick_next;
            eos_reg       <= eos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        neg_reg       <= neg_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        iter_reg      <= iter_next;
        res_level_reg <= res_level_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    // Step table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lvl_mem[mem_waddr] <= in_value;
            len_mem[mem_waddr] <= wlen;
        end
        rd_lvl_reg <= lvl_mem[mem_raddr];
        rd_len_reg <= len_mem[mem_raddr];
    end

    // Table count never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STEPS))
        else $error("step count above table depth");

    // Current step always lies inside a filled table
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(cur_reg) < count_reg))
        else $error("current step beyond step count");

    // A result appears only from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("output word raised outside output state");

    // Divider always finishes into the sign fix-up
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && iter_reg == ITER_W'(DIV_STEPS - 1)) |=> (state_reg == ST_SIGN))
        else $error("divider did not finish after all quotient bits");

endmodule
